### rtl/fmc_pkg.sv
// Package for the Fourier map coefficient unit: widths, register indexes,
// pipeline sideband structs and the square-root and division step functions.
// No dependencies.
package fmc_pkg;

    localparam int W_VAL     = 32;
    localparam int SQ_STAGES = 32;
    localparam int DV_STAGES = 32;

    typedef enum logic [2:0] {
        REG_MAP_TYPE   = 3'd0,
        REG_AMP_INPUT  = 3'd1,
        REG_SCALE_K    = 3'd2,
        REG_SCALE_OFS  = 3'd3,
        REG_USE_OFS    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MAP_CALC = 2'd0,
        MAP_OBS  = 2'd1,
        MAP_DIFF = 2'd2,
        MAP_2FOFC = 2'd3
    } t_map_type;

    typedef struct packed {
        logic signed [W_VAL-1:0] meas;
        logic signed [W_VAL-1:0] re;
        logic signed [W_VAL-1:0] im;
    } t_sq_side;

    typedef struct packed {
        logic signed [W_VAL-1:0] re;
        logic signed [W_VAL-1:0] im;
        logic signed [W_VAL-1:0] m;
        logic                    neg_re;
        logic                    neg_im;
        logic                    zero;
        logic                    sat;
    } t_dv_side;

    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] root;
    } t_sq_st;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } t_dv_st;

    function automatic t_sq_st sq_step(t_sq_st cur, logic [1:0] bits);
        logic [34:0] rem_t;
        logic [34:0] trial;
        t_sq_st      nxt;
        rem_t = {cur.rem[32:0], bits};
        trial = {1'b0, cur.root, 2'b01};
        if (rem_t >= trial) begin
            nxt.rem  = rem_t - trial;
            nxt.root = {cur.root[30:0], 1'b1};
        end else begin
            nxt.rem  = rem_t;
            nxt.root = {cur.root[30:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic t_dv_st dv_step(t_dv_st cur, logic nbit, logic [31:0] dvs);
        logic [32:0] rem_t;
        logic [32:0] diff;
        t_dv_st      nxt;
        rem_t = {cur.rem, nbit};
        diff  = rem_t - {1'b0, dvs};
        if (rem_t >= {1'b0, dvs}) begin
            nxt.rem = diff[31:0];
            nxt.quo = {cur.quo[30:0], 1'b1};
        end else begin
            nxt.rem = rem_t[31:0];
            nxt.quo = {cur.quo[30:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

### rtl/fmc_sqrt_pipe.sv
// Two-lane pipelined integer square root, one result bit per stage.
// Depends on fmc_pkg.
module fmc_sqrt_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [63:0]       i_rad_a,
    input  logic [63:0]       i_rad_b,
    input  fmc_pkg::t_sq_side i_side,
    output logic              o_valid,
    output logic [31:0]       o_root_a,
    output logic [31:0]       o_root_b,
    output fmc_pkg::t_sq_side o_side
);
    import fmc_pkg::*;

    logic        r_vld  [SQ_STAGES];
    logic [63:0] r_rad_a[SQ_STAGES];
    logic [63:0] r_rad_b[SQ_STAGES];
    t_sq_st      r_st_a [SQ_STAGES];
    t_sq_st      r_st_b [SQ_STAGES];
    t_sq_side    r_side [SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQ_STAGES; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < SQ_STAGES; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_a[0]  <= sq_step('0, i_rad_a[63:62]);
        r_st_b[0]  <= sq_step('0, i_rad_b[63:62]);
        r_rad_a[0] <= i_rad_a << 2;
        r_rad_b[0] <= i_rad_b << 2;
        r_side[0]  <= i_side;
        for (int k = 1; k < SQ_STAGES; k++) begin
            r_st_a[k]  <= sq_step(r_st_a[k-1], r_rad_a[k-1][63:62]);
            r_st_b[k]  <= sq_step(r_st_b[k-1], r_rad_b[k-1][63:62]);
            r_rad_a[k] <= r_rad_a[k-1] << 2;
            r_rad_b[k] <= r_rad_b[k-1] << 2;
            r_side[k]  <= r_side[k-1];
        end
    end

    assign o_valid  = r_vld[SQ_STAGES-1];
    assign o_root_a = r_st_a[SQ_STAGES-1].root;
    assign o_root_b = r_st_b[SQ_STAGES-1].root;
    assign o_side   = r_side[SQ_STAGES-1];

endmodule

### rtl/fmc_div_pipe.sv
// Two-lane pipelined restoring divider, 64 by 32 bits to a 32-bit quotient,
// one quotient bit per stage. Depends on fmc_pkg.
module fmc_div_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [63:0]       i_num_a,
    input  logic [63:0]       i_num_b,
    input  logic [31:0]       i_dvs,
    input  fmc_pkg::t_dv_side i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo_a,
    output logic [31:0]       o_quo_b,
    output fmc_pkg::t_dv_side o_side
);
    import fmc_pkg::*;

    logic        r_vld  [DV_STAGES];
    logic [31:0] r_lo_a [DV_STAGES];
    logic [31:0] r_lo_b [DV_STAGES];
    logic [31:0] r_dvs  [DV_STAGES];
    t_dv_st      r_st_a [DV_STAGES];
    t_dv_st      r_st_b [DV_STAGES];
    t_dv_side    r_side [DV_STAGES];

    t_dv_st init_a;
    t_dv_st init_b;

    assign init_a = '{rem: i_num_a[63:32], quo: '0};
    assign init_b = '{rem: i_num_b[63:32], quo: '0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DV_STAGES; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DV_STAGES; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_st_a[0] <= dv_step(init_a, i_num_a[31], i_dvs);
        r_st_b[0] <= dv_step(init_b, i_num_b[31], i_dvs);
        r_lo_a[0] <= i_num_a[31:0] << 1;
        r_lo_b[0] <= i_num_b[31:0] << 1;
        r_dvs[0]  <= i_dvs;
        r_side[0] <= i_side;
        for (int k = 1; k < DV_STAGES; k++) begin
            r_st_a[k] <= dv_step(r_st_a[k-1], r_lo_a[k-1][31], r_dvs[k-1]);
            r_st_b[k] <= dv_step(r_st_b[k-1], r_lo_b[k-1][31], r_dvs[k-1]);
            r_lo_a[k] <= r_lo_a[k-1] << 1;
            r_lo_b[k] <= r_lo_b[k-1] << 1;
            r_dvs[k]  <= r_dvs[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    assign o_valid = r_vld[DV_STAGES-1];
    assign o_quo_a = r_st_a[DV_STAGES-1].quo;
    assign o_quo_b = r_st_b[DV_STAGES-1].quo;
    assign o_side  = r_side[DV_STAGES-1];

endmodule

### rtl/fourier_map_coefficient_unit_core.sv
// Top level of the Fourier map coefficient unit: config registers, amplitude
// and magnitude stages around the sqrt and divide pipelines.
// Depends on fmc_pkg, fmc_sqrt_pipe, fmc_div_pipe.
//
//  channel   handshake                  payload
//  input     start (busy always low)    i_measured, i_calc_re, i_calc_im
//  result    o_valid, one-cycle strobe  o_map_re, o_map_im, o_saturated
//  config    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A transaction is taken every cycle. Its result passes stages 0 to 2, the 32-stage
// square root, stages 3 to 7, the 32-stage divider and the final output register.
// Reset clears the valid chain and restores the register defaults.
// Nothing stalls: the receiver takes every result as it is strobed.
module fourier_map_coefficient_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_measured,
    input  logic signed [31:0] i_calc_re,
    input  logic signed [31:0] i_calc_im,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_map_re,
    output logic signed [31:0] o_map_im,
    output logic               o_saturated
);
    import fmc_pkg::*;

    localparam logic signed [39:0] MAX32 = 40'sd2147483647;
    localparam logic signed [39:0] MIN32 = -40'sd2147483648;

    t_map_type          r_map_type;
    logic               r_amp_input;
    logic [31:0]        r_scale_k;
    logic signed [31:0] r_scale_ofs;
    logic               r_use_ofs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_type  <= MAP_CALC;
            r_amp_input <= 1'b0;
            r_scale_k   <= 32'h0001_0000;
            r_scale_ofs <= '0;
            r_use_ofs   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAP_TYPE:  r_map_type  <= t_map_type'(i_cfg_data[1:0]);
                REG_AMP_INPUT: r_amp_input <= i_cfg_data[0];
                REG_SCALE_K:   r_scale_k   <= i_cfg_data;
                REG_SCALE_OFS: r_scale_ofs <= i_cfg_data;
                REG_USE_OFS:   r_use_ofs   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid chain
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic sq_valid, dv_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_v4 <= 1'b0; r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0 <= start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= sq_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            o_valid <= dv_valid;
        end
    end

    // stage 0: capture
    t_sq_side r0_side;
    always_ff @(posedge i_clk) begin
        r0_side <= '{meas: i_measured, re: i_calc_re, im: i_calc_im};
    end

    // stage 1: squares and intensity radicand
    logic [31:0] n1_ure, n1_uim;
    logic [31:0] n1_inten;
    logic [63:0] r1_sq_re, r1_sq_im, r1_rad_i;
    t_sq_side    r1_side;

    assign n1_ure   = r0_side.re[31] ? 32'(-r0_side.re) : 32'(r0_side.re);
    assign n1_uim   = r0_side.im[31] ? 32'(-r0_side.im) : 32'(r0_side.im);
    assign n1_inten = r0_side.meas[31] ? '0 : 32'(r0_side.meas);

    always_ff @(posedge i_clk) begin
        r1_sq_re <= 64'(n1_ure) * 64'(n1_ure);
        r1_sq_im <= 64'(n1_uim) * 64'(n1_uim);
        r1_rad_i <= {24'd0, n1_inten, 8'd0};
        r1_side  <= r0_side;
    end

    // stage 2: sum of squares
    logic [63:0] r2_sum, r2_rad_i;
    t_sq_side    r2_side;
    always_ff @(posedge i_clk) begin
        r2_sum   <= r1_sq_re + r1_sq_im;
        r2_rad_i <= r1_rad_i;
        r2_side  <= r1_side;
    end

    logic [31:0] sq_mod, sq_root_i;
    t_sq_side    sq_side;

    fmc_sqrt_pipe u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v2),
        .i_rad_a  (r2_sum),
        .i_rad_b  (r2_rad_i),
        .i_side   (r2_side),
        .o_valid  (sq_valid),
        .o_root_a (sq_mod),
        .o_root_b (sq_root_i),
        .o_side   (sq_side)
    );

    // stage 3: scale the root
    logic [51:0] r3_prod;
    logic [31:0] r3_mod;
    t_sq_side    r3_side;
    always_ff @(posedge i_clk) begin
        r3_prod <= 52'(sq_root_i[19:0]) * 52'(r_scale_k);
        r3_mod  <= sq_mod;
        r3_side <= sq_side;
    end

    // stage 4: observed amplitude
    logic signed [39:0] n4_amp, r4_amp;
    logic [31:0]        r4_mod;
    t_sq_side           r4_side;

    always_comb begin
        if (r_amp_input) begin
            n4_amp = 40'(r3_side.meas);
        end else begin
            n4_amp = $signed({4'd0, r3_prod[51:16]});
            if (r_use_ofs) n4_amp = n4_amp + 40'(r_scale_ofs);
        end
    end

    always_ff @(posedge i_clk) begin
        r4_amp  <= n4_amp;
        r4_mod  <= r3_mod;
        r4_side <= r3_side;
    end

    // stage 5: magnitude and clamp
    logic signed [39:0] n5_mod, n5_m;
    logic signed [31:0] r5_m;
    logic               r5_sat;
    logic [31:0]        r5_mod;
    t_sq_side           r5_side;

    assign n5_mod = $signed({8'd0, r4_mod});

    always_comb begin
        case (r_map_type)
            MAP_OBS:  n5_m = r4_amp;
            MAP_DIFF: n5_m = r4_amp - n5_mod;
            default:  n5_m = (r4_amp <<< 1) - n5_mod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n5_m > MAX32) begin
            r5_m <= 32'sh7FFF_FFFF; r5_sat <= 1'b1;
        end else if (n5_m < MIN32) begin
            r5_m <= 32'sh8000_0000; r5_sat <= 1'b1;
        end else begin
            r5_m <= n5_m[31:0]; r5_sat <= 1'b0;
        end
        r5_mod  <= r4_mod;
        r5_side <= r4_side;
    end

    // stage 6: products of magnitudes
    logic [31:0] n6_am, n6_are, n6_aim;
    logic [63:0] r6_pre, r6_pim;
    logic [31:0] r6_mod;
    t_dv_side    r6_side;

    assign n6_am  = r5_m[31] ? 32'(-r5_m) : 32'(r5_m);
    assign n6_are = r5_side.re[31] ? 32'(-r5_side.re) : 32'(r5_side.re);
    assign n6_aim = r5_side.im[31] ? 32'(-r5_side.im) : 32'(r5_side.im);

    always_ff @(posedge i_clk) begin
        r6_pre  <= 64'(n6_am) * 64'(n6_are);
        r6_pim  <= 64'(n6_am) * 64'(n6_aim);
        r6_mod  <= r5_mod;
        r6_side <= '{re: r5_side.re, im: r5_side.im, m: r5_m,
                     neg_re: r5_m[31] ^ r5_side.re[31],
                     neg_im: r5_m[31] ^ r5_side.im[31],
                     zero: (r5_mod == '0), sat: r5_sat};
    end

    // stage 7: add half the divisor for rounding
    logic [63:0] r7_num_re, r7_num_im;
    logic [31:0] r7_mod;
    t_dv_side    r7_side;
    always_ff @(posedge i_clk) begin
        r7_num_re <= r6_pre + 64'(r6_mod >> 1);
        r7_num_im <= r6_pim + 64'(r6_mod >> 1);
        r7_mod    <= r6_mod;
        r7_side   <= r6_side;
    end

    logic [31:0] dv_q_re, dv_q_im;
    t_dv_side    dv_side;

    fmc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_num_a (r7_num_re),
        .i_num_b (r7_num_im),
        .i_dvs   (r7_mod),
        .i_side  (r7_side),
        .o_valid (dv_valid),
        .o_quo_a (dv_q_re),
        .o_quo_b (dv_q_im),
        .o_side  (dv_side)
    );

    // final stage: sign, clamp and select
    logic signed [31:0] n_re, n_im;
    logic               n_sat_re, n_sat_im;

    always_comb begin
        n_sat_re = 1'b0;
        n_sat_im = 1'b0;
        if (dv_side.neg_re)         n_re = 32'(-dv_q_re);
        else if (dv_q_re[31]) begin n_re = 32'sh7FFF_FFFF; n_sat_re = 1'b1; end
        else                        n_re = dv_q_re;
        if (dv_side.neg_im)         n_im = 32'(-dv_q_im);
        else if (dv_q_im[31]) begin n_im = 32'sh7FFF_FFFF; n_sat_im = 1'b1; end
        else                        n_im = dv_q_im;
    end

    always_ff @(posedge i_clk) begin
        if (r_map_type == MAP_CALC) begin
            o_map_re    <= dv_side.re;
            o_map_im    <= dv_side.im;
            o_saturated <= 1'b0;
        end else if (dv_side.zero) begin
            o_map_re    <= dv_side.m;
            o_map_im    <= '0;
            o_saturated <= dv_side.sat;
        end else begin
            o_map_re    <= n_re;
            o_map_im    <= n_im;
            o_saturated <= dv_side.sat | n_sat_re | n_sat_im;
        end
    end

endmodule
